// ===== hdl/bfnn_pkg.sv =====
// Package for the brute-force nearest neighbor unit.
// Holds operation codes, fixed field widths and the token type of the cell chain.
// No dependencies.
package bfnn_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 8;
    localparam int DIST_W    = 26;
    localparam int DIM_REG_W = 5;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 5'd16;

    // Control part of a distance token moving down the cell chain.
    typedef struct packed {
        logic valid;
        logic last;
    } t_bfnn_tok;

endpackage

// ===== hdl/bfnn_if.sv =====
// Channel interfaces of the nearest neighbor unit: input items, results, configuration.
// Depends on bfnn_pkg.
interface bfnn_in_if import bfnn_pkg::*; #(
    parameter int COORD_BITS = 11
) ();
    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              op;
    logic signed [COORD_BITS-1:0] coord;

    modport source (output valid, op, coord, input ready);
    modport sink   (input valid, op, coord, output ready);
endinterface

interface bfnn_out_if import bfnn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_distance;
    logic              empty_set;

    modport source (output valid, nearest_index, nearest_distance, empty_set, input ready);
    modport sink   (input valid, nearest_index, nearest_distance, empty_set, output ready);
endinterface

interface bfnn_cfg_if import bfnn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DIM_REG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/bfnn_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bfnn_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bfnn_cell.sv =====
// One cell of the distance chain: holds one query coordinate and adds its
// squared difference to the passing partial sum. Depends on bfnn_pkg.
module bfnn_cell import bfnn_pkg::*; #(
    parameter int COORD_BITS = 11,
    parameter int SUM_W      = 26
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_we,
    input  logic [COORD_BITS-1:0] i_q_data,
    input  logic                  i_active,
    input  logic [COORD_BITS-1:0] i_coord,
    input  t_bfnn_tok             i_tok,
    input  logic [SUM_W-1:0]      i_sum,
    output t_bfnn_tok             o_tok,
    output logic [SUM_W-1:0]      o_sum
);

    logic [COORD_BITS-1:0]          r_q;
    t_bfnn_tok                      r_tok;
    logic [SUM_W-1:0]               r_sum;
    logic signed [COORD_BITS:0]     w_diff;
    logic signed [2*COORD_BITS+1:0] w_prod;
    logic [2*COORD_BITS-1:0]        w_sq;
    logic [SUM_W-1:0]               n_sum;

    // The square of the difference is never negative and fits in 2*COORD_BITS bits.
    assign w_diff = $signed({i_coord[COORD_BITS-1], i_coord}) - $signed({r_q[COORD_BITS-1], r_q});
    assign w_prod = w_diff * w_diff;
    assign w_sq   = w_prod[2*COORD_BITS-1:0];
    assign n_sum  = i_sum + (i_active ? SUM_W'(w_sq) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_we) begin
            r_q <= i_q_data;
        end
        r_sum <= n_sum;
    end

    assign o_tok = r_tok;
    assign o_sum = r_sum;

endmodule

// ===== hdl/brute_force_nearest_neighbour_unit.sv =====
// Top level of the brute-force nearest neighbor unit: point store, scan sequencer,
// distance cell chain and best-candidate tracking. Depends on bfnn_pkg, bfnn_if,
// bfnn_ram and bfnn_cell.
//
//  Channel  Direction  Payload                                     Transaction
//  i_in     sink       op, coord                                   valid & ready
//  o_res    source     nearest_index, nearest_distance, empty_set  valid & ready
//  i_cfg    sink       data (dimension register)                   valid & ready
//
// Loads, clears and query coordinates that do not finish a query never make the unit busy.
// A finishing query is resolved by a scan through the single read port of the point
// store (one coordinate per cycle) and the DIM_MAX deep cell chain; with no points
// loaded the result is ready without a scan.
// Reset is synchronous and active low; it empties the store and sets the dimension to 16.
// i_in is not ready while a query is being resolved; a result waiting on o_res holds
// only that result, so loads and clears continue while the output is stalled.
module brute_force_nearest_neighbour_unit import bfnn_pkg::*; #(
    parameter int MAX_POINTS = 256,
    parameter int DIM_MAX    = 16,
    parameter int COORD_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfnn_in_if.sink     i_in,
    bfnn_out_if.source  o_res,
    bfnn_cfg_if.sink    i_cfg
);

    // Widths: point index, loaded count, coordinate slot, effective dimension, sums.
    localparam int PT_W      = $clog2(MAX_POINTS);
    localparam int LD_W      = $clog2(MAX_POINTS + 1);
    localparam int KW        = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int DW        = $clog2(DIM_MAX + 1);
    localparam int SUM_W     = 2 * COORD_BITS + ((DIM_MAX > 1) ? $clog2(DIM_MAX) : 0);
    localparam int AW        = PT_W + KW;
    localparam int MEM_DEPTH = MAX_POINTS << KW;

    // Configuration and fill state.
    logic [DIM_REG_W-1:0] r_dim_raw;
    logic [LD_W-1:0]      r_loaded;
    logic [KW-1:0]        r_load_pos;
    logic [KW-1:0]        r_query_pos;

    // Scan control.
    logic                 r_busy;
    logic                 r_scan;
    logic [PT_W-1:0]      r_scan_pt;
    logic [KW-1:0]        r_scan_k;
    t_bfnn_tok            r_rd_tok;

    // Best candidate so far.
    logic                 r_have;
    logic [PT_W-1:0]      r_cnt;
    logic [PT_W-1:0]      r_best_idx;
    logic [SUM_W-1:0]     r_best_sum;
    logic                 r_best_empty;
    logic                 r_done;

    // Output register.
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [DIST_W-1:0]    r_out_dist;
    logic                 r_out_empty;

    logic [DW-1:0]         w_dim;
    logic [KW-1:0]         w_dim_last;
    logic [KW-1:0]         w_load_k;
    logic [KW-1:0]         w_query_k;
    logic [PT_W-1:0]       w_last_pt;
    logic                  w_in_acc;
    logic                  w_cfg_acc;
    logic                  w_load;
    logic                  w_query;
    logic                  w_q_done;
    logic                  w_out_move;
    logic [COORD_BITS-1:0] w_rdata;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;

    t_bfnn_tok             w_tok [DIM_MAX+1];
    logic [SUM_W-1:0]      w_sum [DIM_MAX+1];

    // A dimension of zero acts as one, and anything above DIM_MAX acts as DIM_MAX.
    always_comb begin
        if (r_dim_raw == '0) begin
            w_dim = DW'(1);
        end else if (int'(r_dim_raw) > DIM_MAX) begin
            w_dim = DW'(DIM_MAX);
        end else begin
            w_dim = DW'(r_dim_raw);
        end
    end

    assign w_dim_last = KW'(w_dim - DW'(1));
    assign w_load_k   = (DW'(r_load_pos) >= w_dim) ? '0 : r_load_pos;
    assign w_query_k  = (DW'(r_query_pos) >= w_dim) ? '0 : r_query_pos;
    assign w_last_pt  = PT_W'(r_loaded - LD_W'(1));

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_cfg_acc = i_cfg.valid && i_cfg.ready;
    assign w_load    = w_in_acc && (i_in.op == OP_LOAD) && (r_loaded != LD_W'(MAX_POINTS));
    assign w_query   = w_in_acc && (i_in.op == OP_QUERY);
    assign w_q_done  = w_query && (w_query_k == w_dim_last);

    // The finished result moves into the output register once that register is free.
    assign w_out_move = r_done && (!r_out_valid || o_res.ready);

    assign i_in.ready  = !r_busy;
    assign i_cfg.ready = !r_busy;

    // Each point occupies a row of 2**KW coordinate slots in the store.
    assign w_waddr = {r_loaded[PT_W-1:0], w_load_k};
    assign w_raddr = {r_scan_pt, r_scan_k};

    bfnn_ram #(
        .WIDTH (COORD_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_waddr),
        .i_wdata (i_in.coord),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The cell chain. A token enters cell 0 in the cycle the store shows coordinate 0
    // of its point; in the next cycle it sits at cell 1 while the store shows coordinate 1,
    // and so on. Cells at or beyond the active dimension pass the sum unchanged, so every
    // token passes through all DIM_MAX cells before it leaves the chain.
    assign w_tok[0] = r_rd_tok;
    assign w_sum[0] = '0;

    for (genvar k = 0; k < DIM_MAX; k++) begin : g_cell
        logic w_q_we;
        logic w_active;

        assign w_q_we   = w_query && (w_query_k == KW'(k));
        assign w_active = DW'(k) < w_dim;

        bfnn_cell #(
            .COORD_BITS (COORD_BITS),
            .SUM_W      (SUM_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_q_we   (w_q_we),
            .i_q_data (i_in.coord),
            .i_active (w_active),
            .i_coord  (w_rdata),
            .i_tok    (w_tok[k]),
            .i_sum    (w_sum[k]),
            .o_tok    (w_tok[k+1]),
            .o_sum    (w_sum[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_raw   <= DIM_RESET;
            r_loaded    <= '0;
            r_load_pos  <= '0;
            r_query_pos <= '0;
            r_busy      <= 1'b0;
            r_scan      <= 1'b0;
            r_rd_tok    <= '0;
            r_have      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Input transactions.
            if (w_in_acc) begin
                unique case (i_in.op)
                    OP_LOAD: begin
                        if (w_load) begin
                            if (w_load_k == w_dim_last) begin
                                r_load_pos <= '0;
                                r_loaded   <= r_loaded + LD_W'(1);
                            end else begin
                                r_load_pos <= w_load_k + KW'(1);
                            end
                        end
                    end
                    OP_QUERY: begin
                        if (w_q_done) begin
                            r_query_pos <= '0;
                            r_busy      <= 1'b1;
                            r_have      <= 1'b0;
                            if (r_loaded == '0) begin
                                r_done <= 1'b1;
                            end else begin
                                r_scan <= 1'b1;
                            end
                        end else begin
                            r_query_pos <= w_query_k + KW'(1);
                        end
                    end
                    OP_CLEAR: begin
                        r_loaded   <= '0;
                        r_load_pos <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // A dimension write drops partly loaded points and partly fed queries.
            if (w_cfg_acc) begin
                r_dim_raw   <= i_cfg.data;
                r_load_pos  <= '0;
                r_query_pos <= '0;
            end

            // Read sequencer: one coordinate per cycle, point by point.
            if (r_scan) begin
                if (r_scan_k == w_dim_last) begin
                    if (r_scan_pt == w_last_pt) begin
                        r_scan <= 1'b0;
                    end
                end
            end
            r_rd_tok.valid <= r_scan && (r_scan_k == '0);
            r_rd_tok.last  <= r_scan_pt == w_last_pt;

            // Tokens leave the chain in point order; a strict compare keeps the lowest
            // index on ties.
            if (w_tok[DIM_MAX].valid) begin
                r_have <= 1'b1;
                if (w_tok[DIM_MAX].last) begin
                    r_done <= 1'b1;
                end
            end

            if (w_out_move) begin
                r_done      <= 1'b0;
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_q_done) begin
            r_scan_pt    <= '0;
            r_scan_k     <= '0;
            r_cnt        <= '0;
            r_best_idx   <= '0;
            r_best_sum   <= '0;
            r_best_empty <= (r_loaded == '0);
        end else begin
            if (r_scan) begin
                if (r_scan_k == w_dim_last) begin
                    r_scan_k  <= '0;
                    r_scan_pt <= r_scan_pt + PT_W'(1);
                end else begin
                    r_scan_k <= r_scan_k + KW'(1);
                end
            end
            if (w_tok[DIM_MAX].valid) begin
                r_cnt <= r_cnt + PT_W'(1);
                if (!r_have || (w_sum[DIM_MAX] < r_best_sum)) begin
                    r_best_sum <= w_sum[DIM_MAX];
                    r_best_idx <= r_cnt;
                end
            end
        end

        if (w_out_move) begin
            r_out_idx   <= IDX_W'(r_best_idx);
            r_out_dist  <= DIST_W'(r_best_sum);
            r_out_empty <= r_best_empty;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.nearest_index    = r_out_idx;
    assign o_res.nearest_distance = r_out_dist;
    assign o_res.empty_set        = r_out_empty;

endmodule
